[src/segment_triangle_intersect_top_assert.svh]
// Assertion macros for the segment / triangle intersection block.
// The checker that uses them provides clk and rst.
`ifndef SEGMENT_TRIANGLE_INTERSECT_TOP_ASSERT_SVH
`define SEGMENT_TRIANGLE_INTERSECT_TOP_ASSERT_SVH

// Checked outside reset only
`define STI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define STI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/sti_pkg.sv]
package sti_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int EPS_W      = 48;

  localparam logic [EPS_W-1:0] EPS_RESET = 48'd17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_DELTA_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_DELTA_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_DELTA_Z  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DET_EPSILON  = 3'd6;

  // divider lanes
  localparam int NUM_LANES = 3;
  localparam int LANE_T    = 0;
  localparam int LANE_U    = 1;
  localparam int LANE_V    = 2;

endpackage

[src/sti_div.sv]
module sti_div
  import sti_pkg::*;
#(
  parameter int DW    = 51,
  parameter int QUO_W = 17
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_hit,
  input  logic [DW-1:0]                       in_den,
  input  logic [NUM_LANES-1:0][DW-1:0]        in_num,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_hit,
  output logic [NUM_LANES-1:0][QUO_W-1:0]     out_quo
);

  // restoring divider, one quotient bit per stage, three lanes sharing den
  logic [QUO_W-1:0]                   vld;
  logic [QUO_W-1:0]                   en;
  logic [QUO_W-1:0]                   hit_s;
  logic [DW-1:0]                      den_s [QUO_W];
  logic [NUM_LANES-1:0][DW-1:0]       rem_s [QUO_W];
  logic [NUM_LANES-1:0][QUO_W-1:0]    quo_s [QUO_W];

  always_comb begin
    en[QUO_W-1] = ~vld[QUO_W-1] | out_ready;
    for (int j = QUO_W - 2; j >= 0; j--) begin
      en[j] = ~vld[j] | en[j+1];
    end
  end

  assign in_ready = en[0];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    logic                               v_in;
    logic                               h_in;
    logic [DW-1:0]                      d_in;
    logic [NUM_LANES-1:0][DW:0]         trial;
    logic [NUM_LANES-1:0][QUO_W-1:0]    quo_prev;
    logic [NUM_LANES-1:0]               ge;
    logic [NUM_LANES-1:0][DW-1:0]       rem_next;
    logic [NUM_LANES-1:0][QUO_W-1:0]    quo_next;

    if (j == 0) begin : g_first
      assign v_in     = in_valid;
      assign h_in     = in_hit;
      assign d_in     = in_den;
      assign quo_prev = '0;
      always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
          trial[l] = {1'b0, in_num[l]};
        end
      end
    end else begin : g_rest
      assign v_in     = vld[j-1];
      assign h_in     = hit_s[j-1];
      assign d_in     = den_s[j-1];
      assign quo_prev = quo_s[j-1];
      always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
          trial[l] = {rem_s[j-1][l], 1'b0};
        end
      end
    end

    always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
        ge[l] = trial[l] >= {1'b0, d_in};
        rem_next[l] = ge[l] ? DW'(trial[l] - {1'b0, d_in}) : DW'(trial[l]);
        quo_next[l] = {quo_prev[l][QUO_W-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en[j]) begin
        vld[j] <= v_in;
      end
      if (en[j]) begin
        hit_s[j] <= h_in;
        den_s[j] <= d_in;
        rem_s[j] <= rem_next;
        quo_s[j] <= quo_next;
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign out_hit   = hit_s[QUO_W-1];
  assign out_quo   = quo_s[QUO_W-1];

endmodule

[src/segment_triangle_intersect_top.sv]
// Channel   Dir  Signals                        Contents
// s_*       in   s_tvalid s_tready s_tdata      one triangle: vertex 0, edge a, edge b
// m_*       out  m_tvalid m_tready m_tdata      t, u, v quotients; m_tuser = hit
// cfg_*     in   cfg_we cfg_index cfg_data      segment origin, delta, det epsilon
//
// One triangle per cycle sustained while m_tready is held high. The pipeline
// is seven arithmetic stages, then the restoring divider that retires one
// quotient bit per stage.
// Reset is synchronous; it empties the pipeline and restores register defaults.
// A stall holds only the stages that are full; bubbles close up behind it.
module segment_triangle_intersect_top
  import sti_pkg::*;
#(
  parameter int COORD_BITS       = 16,
  parameter int RESULT_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // tri_origin_x/y/z, edge_a_x/y/z, edge_b_x/y/z, COORD_BITS each, zero padded
  input  logic [((9*COORD_BITS+7)/8)*8-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // t_hit, u_hit, v_hit, RESULT_FRAC_BITS+1 each, zero padded
  output logic [((3*(RESULT_FRAC_BITS+1)+7)/8)*8-1:0] m_tdata,
  // hit
  output logic                                m_tuser,
  input  logic                                cfg_we,
  input  logic [CFG_IDX_W-1:0]                cfg_index,
  input  logic [CFG_DATA_W-1:0]               cfg_data
);

  localparam int C     = COORD_BITS;
  localparam int RW    = RESULT_FRAC_BITS + 1;
  localparam int SW    = C + 1;
  localparam int PPW   = 2 * C;
  localparam int PW    = 2 * C + 1;
  localparam int QPW   = 2 * C + 1;
  localparam int QW    = 2 * C + 2;
  localparam int APW   = 3 * C + 1;
  localparam int SPW   = 3 * C + 2;
  localparam int NW    = 3 * C + 4;
  localparam int DW    = 3 * C + 3;
  localparam int EW    = (NW > EPS_W) ? NW : EPS_W;
  localparam int OUT_W = ((3 * RW + 7) / 8) * 8;

  // configuration
  logic signed [C-1:0] so [3];
  logic signed [C-1:0] sd [3];
  logic [EPS_W-1:0]    eps;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        so[k] <= '0;
        sd[k] <= '0;
      end
      eps <= EPS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEG_ORIGIN_X: so[0] <= cfg_data[C-1:0];
        REG_SEG_ORIGIN_Y: so[1] <= cfg_data[C-1:0];
        REG_SEG_ORIGIN_Z: so[2] <= cfg_data[C-1:0];
        REG_SEG_DELTA_X:  sd[0] <= cfg_data[C-1:0];
        REG_SEG_DELTA_Y:  sd[1] <= cfg_data[C-1:0];
        REG_SEG_DELTA_Z:  sd[2] <= cfg_data[C-1:0];
        REG_DET_EPSILON:  eps   <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic signed [C-1:0] fo [3];
  logic signed [C-1:0] fa [3];
  logic signed [C-1:0] fb [3];

  for (genvar k = 0; k < 3; k++) begin : g_in
    assign fo[k] = s_tdata[k*C +: C];
    assign fa[k] = s_tdata[(k+3)*C +: C];
    assign fb[k] = s_tdata[(k+6)*C +: C];
  end

  // stage handshake
  logic [7:1] vld;
  logic [7:1] en;
  logic       div_ready;

  always_comb begin
    en[7] = ~vld[7] | div_ready;
    for (int k = 6; k >= 1; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  assign s_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: s = seg origin - vertex 0, products for p = delta x b
  logic signed [SW-1:0]  s1_s  [3];
  logic signed [PPW-1:0] s1_pd [6];
  logic signed [C-1:0]   s1_a  [3];
  logic signed [C-1:0]   s1_b  [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        s1_s[k]       <= SW'(so[k]) - SW'(fo[k]);
        s1_pd[2*k]    <= PPW'(sd[(k+1)%3]) * PPW'(fb[(k+2)%3]);
        s1_pd[2*k+1]  <= PPW'(sd[(k+2)%3]) * PPW'(fb[(k+1)%3]);
        s1_a[k]       <= fa[k];
        s1_b[k]       <= fb[k];
      end
    end
  end

  // stage 2: p, products for q = s x a
  logic signed [PW-1:0]  s2_p  [3];
  logic signed [QPW-1:0] s2_qd [6];
  logic signed [SW-1:0]  s2_s  [3];
  logic signed [C-1:0]   s2_a  [3];
  logic signed [C-1:0]   s2_b  [3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        s2_p[k]       <= PW'(s1_pd[2*k]) - PW'(s1_pd[2*k+1]);
        s2_qd[2*k]    <= QPW'(s1_s[(k+1)%3]) * QPW'(s1_a[(k+2)%3]);
        s2_qd[2*k+1]  <= QPW'(s1_s[(k+2)%3]) * QPW'(s1_a[(k+1)%3]);
        s2_s[k]       <= s1_s[k];
        s2_a[k]       <= s1_a[k];
        s2_b[k]       <= s1_b[k];
      end
    end
  end

  // stage 3: q, products for det = a.p and nu = s.p
  logic signed [QW-1:0]  s3_q  [3];
  logic signed [APW-1:0] s3_ap [3];
  logic signed [SPW-1:0] s3_sp [3];
  logic signed [C-1:0]   s3_b  [3];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        s3_q[k]  <= QW'(s2_qd[2*k]) - QW'(s2_qd[2*k+1]);
        s3_ap[k] <= APW'(s2_a[k]) * APW'(s2_p[k]);
        s3_sp[k] <= SPW'(s2_s[k]) * SPW'(s2_p[k]);
        s3_b[k]  <= s2_b[k];
      end
    end
  end

  // stage 4: det, nu, products for nv = delta.q and nt = b.q
  logic signed [NW-1:0]  s4_det;
  logic signed [NW-1:0]  s4_nu;
  logic signed [SPW-1:0] s4_dq [3];
  logic signed [SPW-1:0] s4_bq [3];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_det <= NW'(s3_ap[0]) + NW'(s3_ap[1]) + NW'(s3_ap[2]);
      s4_nu  <= NW'(s3_sp[0]) + NW'(s3_sp[1]) + NW'(s3_sp[2]);
      for (int k = 0; k < 3; k++) begin
        s4_dq[k] <= SPW'(sd[k]) * SPW'(s3_q[k]);
        s4_bq[k] <= SPW'(s3_b[k]) * SPW'(s3_q[k]);
      end
    end
  end

  // stage 5: nv, nt
  logic signed [NW-1:0] s5_det;
  logic signed [NW-1:0] s5_nu;
  logic signed [NW-1:0] s5_nv;
  logic signed [NW-1:0] s5_nt;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_det <= s4_det;
      s5_nu  <= s4_nu;
      s5_nv  <= NW'(s4_dq[0]) + NW'(s4_dq[1]) + NW'(s4_dq[2]);
      s5_nt  <= NW'(s4_bq[0]) + NW'(s4_bq[1]) + NW'(s4_bq[2]);
    end
  end

  // stage 6: fold the sign of det into all four values
  logic signed [NW-1:0] s6_det;
  logic signed [NW-1:0] s6_nu;
  logic signed [NW-1:0] s6_nv;
  logic signed [NW-1:0] s6_nt;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      if (s5_det < 0) begin
        s6_det <= -s5_det;
        s6_nu  <= -s5_nu;
        s6_nv  <= -s5_nv;
        s6_nt  <= -s5_nt;
      end else begin
        s6_det <= s5_det;
        s6_nu  <= s5_nu;
        s6_nv  <= s5_nv;
        s6_nt  <= s5_nt;
      end
    end
  end

  // stage 7: hit decision
  logic                          s7_hit;
  logic [DW-1:0]                 s7_den;
  logic [NUM_LANES-1:0][DW-1:0]  s7_num;
  logic                          hit_c;
  logic signed [NW:0]            uv_sum;

  assign uv_sum = (NW+1)'(s6_nu) + (NW+1)'(s6_nv);

  assign hit_c = (s6_det != 0)
              && (EW'($unsigned(s6_det)) >= EW'(eps))
              && (s6_nu >= 0) && (s6_nu <= s6_det)
              && (s6_nv >= 0) && (uv_sum <= (NW+1)'(s6_det))
              && (s6_nt >= 0) && (s6_nt <= s6_det);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_hit         <= hit_c;
      s7_den         <= s6_det[DW-1:0];
      s7_num[LANE_T] <= s6_nt[DW-1:0];
      s7_num[LANE_U] <= s6_nu[DW-1:0];
      s7_num[LANE_V] <= s6_nv[DW-1:0];
    end
  end

  // quotients
  logic                          div_hit;
  logic [NUM_LANES-1:0][RW-1:0]  div_quo;

  sti_div #(
    .DW    (DW),
    .QUO_W (RW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[7]),
    .in_ready  (div_ready),
    .in_hit    (s7_hit),
    .in_den    (s7_den),
    .in_num    (s7_num),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_hit   (div_hit),
    .out_quo   (div_quo)
  );

  assign m_tuser = div_hit;
  assign m_tdata = div_hit ? OUT_W'({div_quo[LANE_V], div_quo[LANE_U], div_quo[LANE_T]})
                           : '0;

endmodule

[src/sti_check.sv]
`include "segment_triangle_intersect_top_assert.svh"

module sti_check #(
  parameter int RESULT_FRAC_BITS = 16
) (
  input logic                                           clk,
  input logic                                           rst,
  input logic                                           m_tvalid,
  input logic                                           m_tready,
  input logic [((3*(RESULT_FRAC_BITS+1)+7)/8)*8-1:0]    m_tdata,
  input logic                                           m_tuser
);

  localparam int RW = RESULT_FRAC_BITS + 1;
  localparam logic [RW:0] ONE = (RW+1)'(1) << RESULT_FRAC_BITS;

  `STI_ASSERT_ALWAYS(a_reset_empties, rst |=> !m_tvalid, "output valid after reset")

  `STI_ASSERT(a_stall_holds, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

  `STI_ASSERT(a_miss_zero, m_tvalid && !m_tuser |-> m_tdata == '0, "miss with nonzero data")

  // barycentric sum and t stay within one on a hit
  `STI_ASSERT(a_hit_range, m_tvalid && m_tuser |-> ((RW+1)'(m_tdata[2*RW-1:RW]) + (RW+1)'(m_tdata[3*RW-1:2*RW]) <= ONE) && ((RW+1)'(m_tdata[RW-1:0]) <= ONE), "hit quotient out of range")

endmodule

bind segment_triangle_intersect_top sti_check #(
  .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
) u_sti_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[verif/tb_segment_triangle_intersect_top.sv]
module tb_segment_triangle_intersect_top;
  import sti_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // beyond the register list
  localparam int DRAIN_CYCLES = 40;

  typedef logic signed [15:0] coord_t;

  // ox at the lowest bits, so the struct is the tdata layout
  typedef struct packed {
    coord_t bz, by, bx, az, ay, ax, oz, oy, ox;
  } triangle_t;

  typedef struct {
    logic        hit;
    logic [16:0] t, u, v;
  } crossing_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [55:0]  m_tdata;
  logic         m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  segment_triangle_intersect_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // shadow of the segment registers
  coord_t      seg_org[3];
  coord_t      seg_dir[3];
  logic [47:0] eps_shadow;

  crossing_t   pending_crossings[$];
  int          mismatches = 0;
  bit          no_gaps = 1'b0;
  int          hold_request = 0;

  function automatic logic [16:0] quotient_q16(longint num, longint den);
    longint q, rem;
    q = 0;
    rem = num;
    if (rem >= den) begin
      q = 1;
      rem -= den;
    end
    for (int i = 0; i < 16; i++) begin
      rem = rem <<< 1;
      q = q <<< 1;
      if (rem >= den) begin
        rem -= den;
        q |= 1;
      end
    end
    return q[16:0];
  endfunction

  function automatic crossing_t predict_crossing(triangle_t tr);
    crossing_t r;
    longint dx, dy, dz, sx, sy, sz, ax, ay, az, bx, by, bz;
    longint px, py, pz, qx, qy, qz, det, nu, nv, nt;
    dx = seg_dir[0]; dy = seg_dir[1]; dz = seg_dir[2];
    ax = tr.ax; ay = tr.ay; az = tr.az;
    bx = tr.bx; by = tr.by; bz = tr.bz;
    sx = longint'(seg_org[0]) - longint'(tr.ox);
    sy = longint'(seg_org[1]) - longint'(tr.oy);
    sz = longint'(seg_org[2]) - longint'(tr.oz);
    px = dy * bz - dz * by;
    py = dz * bx - dx * bz;
    pz = dx * by - dy * bx;
    det = ax * px + ay * py + az * pz;
    qx = sy * az - sz * ay;
    qy = sz * ax - sx * az;
    qz = sx * ay - sy * ax;
    nu = sx * px + sy * py + sz * pz;
    nv = dx * qx + dy * qy + dz * qz;
    nt = bx * qx + by * qy + bz * qz;
    if (det < 0) begin
      det = -det; nu = -nu; nv = -nv; nt = -nt;
    end
    r.hit = det != 0 && det >= longint'({16'd0, eps_shadow}) &&
            nu >= 0 && nu <= det && nv >= 0 && nu + nv <= det &&
            nt >= 0 && nt <= det;
    r.t = r.hit ? quotient_q16(nt, det) : '0;
    r.u = r.hit ? quotient_q16(nu, det) : '0;
    r.v = r.hit ? quotient_q16(nv, det) : '0;
    return r;
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SEG_ORIGIN_X: seg_org[0] = value[15:0];
      REG_SEG_ORIGIN_Y: seg_org[1] = value[15:0];
      REG_SEG_ORIGIN_Z: seg_org[2] = value[15:0];
      REG_SEG_DELTA_X:  seg_dir[0] = value[15:0];
      REG_SEG_DELTA_Y:  seg_dir[1] = value[15:0];
      REG_SEG_DELTA_Z:  seg_dir[2] = value[15:0];
      REG_DET_EPSILON:  eps_shadow = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_segment(coord_t ox, coord_t oy, coord_t oz,
                             coord_t dx, coord_t dy, coord_t dz, logic [47:0] eps);
    write_reg(REG_SEG_ORIGIN_X, {{32{ox[15]}}, ox});
    write_reg(REG_SEG_ORIGIN_Y, {32'hdead_beef, oy});  // upper bits ignored
    write_reg(REG_SEG_ORIGIN_Z, {{32{oz[15]}}, oz});
    write_reg(REG_SEG_DELTA_X, {32'h0, dx});
    write_reg(REG_SEG_DELTA_Y, {{32{dy[15]}}, dy});
    write_reg(REG_SEG_DELTA_Z, {32'hffff_0000, dz});
    write_reg(REG_DET_EPSILON, eps);
  endtask

  task automatic send_triangle(triangle_t tr);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= tr;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_crossings.push_back(predict_crossing(tr));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_crossings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic triangle_t noise_triangle();
    triangle_t tr;
    tr = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
    return tr;
  endfunction

  // triangle lying across the segment midpoint, spanning mostly x and y
  function automatic triangle_t aimed_triangle();
    triangle_t tr;
    int spread;
    spread = ($urandom_range(0, 9) == 0) ? 8000 : 600;
    tr.ox = coord_t'(seg_org[0] + (seg_dir[0] >>> 1) - $urandom_range(0, spread / 2));
    tr.oy = coord_t'(seg_org[1] + (seg_dir[1] >>> 1) - $urandom_range(0, spread / 2));
    tr.oz = coord_t'(seg_org[2] + (seg_dir[2] >>> 1) + $urandom_range(0, spread)
                     - spread / 2);
    tr.ax = coord_t'($urandom_range(0, spread));
    tr.ay = coord_t'($urandom_range(0, 200) - 100);
    tr.az = coord_t'($urandom_range(0, 200) - 100);
    tr.bx = coord_t'($urandom_range(0, 200) - 100);
    tr.by = coord_t'($urandom_range(0, spread));
    tr.bz = coord_t'($urandom_range(0, 200) - 100);
    if ($urandom_range(0, 1)) begin
      tr.ax = tr.bx; tr.ay = tr.by; tr.az = tr.bz;  // swap for negative det
      tr.bx = coord_t'($urandom_range(0, spread));
      tr.by = coord_t'($urandom_range(0, 200) - 100);
      tr.bz = coord_t'($urandom_range(0, 200) - 100);
    end
    return tr;
  endfunction

  task automatic test_directed();
    set_segment(16'sd64, 16'sd64, -16'sd256, 16'sd0, 16'sd0, 16'sd512, EPS_RESET);
    // plain hit, t = 0.5, u = v = 0.25 region
    send_triangle('{bz:0, by:256, bx:0, az:0, ay:0, ax:256, oz:0, oy:0, ox:0});
    // swapped edges, negative det
    send_triangle('{bz:0, by:0, bx:256, az:0, ay:256, ax:0, oz:0, oy:0, ox:0});
    // hit exactly at vertex 0
    send_triangle('{bz:0, by:256, bx:0, az:0, ay:0, ax:256, oz:0, oy:64, ox:64});
    // t = 0 and t = 1
    send_triangle('{bz:0, by:256, bx:0, az:0, ay:0, ax:256, oz:-256, oy:0, ox:0});
    send_triangle('{bz:0, by:256, bx:0, az:0, ay:0, ax:256, oz:256, oy:0, ox:0});
    // just past t = 1
    send_triangle('{bz:0, by:256, bx:0, az:0, ay:0, ax:256, oz:257, oy:0, ox:0});
    // on the far edge, u + v = 1
    send_triangle('{bz:0, by:128, bx:0, az:0, ay:0, ax:128, oz:0, oy:0, ox:0});
    // outside the far edge
    send_triangle('{bz:0, by:127, bx:0, az:0, ay:0, ax:128, oz:0, oy:0, ox:0});
    // parallel: plane contains the segment direction
    send_triangle('{bz:256, by:0, bx:0, az:0, ay:0, ax:256, oz:0, oy:0, ox:0});
    // small det, still above the default epsilon
    send_triangle('{bz:0, by:1, bx:0, az:0, ay:0, ax:1, oz:0, oy:64, ox:64});
    // field extremes
    send_triangle({9{16'h7fff}});
    send_triangle({9{16'h8000}});
    send_triangle({9{16'h0000}});
    send_triangle({9{16'hffff}});
    send_triangle({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                   16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
    drain();
    // nearly parallel now misses
    write_reg(REG_DET_EPSILON, 48'd1000);
    send_triangle('{bz:0, by:1, bx:0, az:0, ay:0, ax:1, oz:0, oy:64, ox:64});
    send_triangle('{bz:0, by:256, bx:0, az:0, ay:0, ax:256, oz:0, oy:0, ox:0});
    drain();
    // zero det with zero epsilon still misses; bad index must not touch anything
    write_reg(REG_DET_EPSILON, 48'd0);
    write_reg(REG_UNUSED, 48'hffff_ffff_ffff);
    send_triangle('{bz:256, by:0, bx:0, az:0, ay:0, ax:256, oz:0, oy:0, ox:0});
    send_triangle('{bz:0, by:1, bx:0, az:0, ay:0, ax:1, oz:0, oy:64, ox:64});
    drain();
  endtask

  task automatic test_random_phase(int count, int noise_pct);
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) no_gaps = $urandom_range(0, 2) == 0;
      if ($urandom_range(0, 99) < noise_pct) send_triangle(noise_triangle());
      else send_triangle(aimed_triangle());
    end
    no_gaps = 1'b0;
    drain();
  endtask

  task automatic test_random();
    set_segment(16'sd64, 16'sd64, -16'sd256, 16'sd0, 16'sd0, 16'sd512, EPS_RESET);
    test_random_phase(350, 15);
    set_segment(-16'sd1000, 16'sd200, -16'sd500, 16'sd2000, -16'sd300, 16'sd1000,
                48'({$urandom, $urandom} & 48'h3ff));
    test_random_phase(300, 15);
    // extremes of the segment registers
    set_segment(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 48'd0);
    test_random_phase(150, 50);
    set_segment(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                48'hffff_ffff_ffff);
    test_random_phase(100, 50);
    set_segment(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                48'({$urandom, $urandom}));
    test_random_phase(100, 50);
  endtask

  task automatic test_backpressure();
    set_segment(16'sd64, 16'sd64, -16'sd256, 16'sd0, 16'sd0, 16'sd512, EPS_RESET);
    no_gaps = 1'b1;
    hold_request = 300;
    for (int i = 0; i < 150; i++) send_triangle(aimed_triangle());
    no_gaps = 1'b0;
    drain();
  endtask

  // receiver side: random stalls, plus a long hold-off on request
  initial begin
    int stall, hold;
    stall = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        stall = gap_length();
        m_tready <= (stall == 0);
      end
    end
  end

  always @(posedge clk) begin
    crossing_t exp_c;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_crossings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %h/%b", m_tdata, m_tuser);
      end else begin
        exp_c = pending_crossings.pop_front();
        if (m_tuser !== exp_c.hit || m_tdata[16:0] !== exp_c.t ||
            m_tdata[33:17] !== exp_c.u || m_tdata[50:34] !== exp_c.v) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit %b t %h u %h v %h, got hit %b t %h u %h v %h",
                     exp_c.hit, exp_c.t, exp_c.u, exp_c.v,
                     m_tuser, m_tdata[16:0], m_tdata[33:17], m_tdata[50:34]);
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    seg_org = '{0, 0, 0};
    seg_dir = '{0, 0, 0};
    eps_shadow = EPS_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset values: zero delta, every triangle misses
    for (int i = 0; i < 5; i++) send_triangle(noise_triangle());
    drain();
    test_directed();
    test_backpressure();
    test_random();
    if (mismatches == 0 && pending_crossings.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/sti_pkg.sv
src/sti_div.sv
src/segment_triangle_intersect_top.sv
src/sti_check.sv
verif/tb_segment_triangle_intersect_top.sv
